/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled during reset
`define ASSERT_AT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// clocked assertion, also checked during reset
`define ASSERT_ALWAYS(lbl, ck, prop, msg) \
    lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

/* design/ptc_pkg.sv */
package ptc_pkg;

    localparam int CAL_W      = 48;
    localparam int RAW_W      = 20;
    localparam int OUT_W      = 32;
    localparam int DIVR_W     = 31;
    localparam int DIV_STAGES = 64;
    localparam int FRONT_STAGES = 10;
    localparam int TAIL_STAGES  = 7;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    localparam logic [63:0] PRESS_BIAS = 64'h0000_8000_0000_0000;
    localparam logic [11:0] DIV_SCALE  = 12'd3125;
    localparam logic [20:0] PRESS_BASE = 21'd1048576;

    typedef enum logic [1:0] {
        REG_TEMP_CALIB  = 2'd0,
        REG_PRESS_LOW   = 2'd1,
        REG_PRESS_MID   = 2'd2,
        REG_PRESS_HIGH  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } cal_t;

    typedef struct packed {
        logic [OUT_W-1:0]  temp;
        logic [63:0]       numer;
        logic [DIVR_W-1:0] divisor;
        logic              invalid;
    } job_t;

endpackage

/* design/ptc_front.sv */
module ptc_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ptc_pkg::cal_t             cal,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ptc_pkg::RAW_W-1:0] raw_temperature,
    input  logic [ptc_pkg::RAW_W-1:0] raw_pressure,
    output logic                      job_valid,
    input  logic                      job_ready,
    output ptc_pkg::job_t             job
);
    import ptc_pkg::*;

    logic [FRONT_STAGES-1:0] vld_reg;
    logic                    en;

    logic [RAW_W-1:0]   adc_t_s0_reg, adc_p_s0_reg;
    logic signed [34:0] ta_s1_reg;
    logic [32:0]        dd_s1_reg;
    logic [20:0]        pb_s1_reg, pb_s2_reg, pb_s3_reg, pb_s4_reg, pb_s5_reg;
    logic [20:0]        pb_s6_reg, pb_s7_reg;
    logic signed [23:0] a_s2_reg;
    logic signed [37:0] b1_s2_reg;
    logic signed [25:0] fine_s3_reg;
    logic signed [26:0] x_s4_reg;
    logic [31:0]        temp_s4_reg, temp_s5_reg, temp_s6_reg, temp_s7_reg, temp_s8_reg;
    logic [53:0]        xx_s5_reg;
    logic signed [42:0] xp5_s5_reg, xp2_s5_reg, xp5_s6_reg, xp2_s6_reg;
    logic [63:0]        y6_s6_reg, x3_s6_reg, y_s7_reg, xs_s7_reg, xm_s8_reg, n0_s8_reg;
    job_t               job_reg;

    logic signed [17:0] diff_next, d_next;
    logic signed [35:0] dsq;
    logic signed [29:0] t5;
    logic signed [53:0] xsq;
    logic signed [70:0] y6_full, x3_full;
    logic [63:0]        xp5_ext, xp2_ext, p4_ext, xs_u;
    logic [79:0]        xm_full;
    logic [75:0]        n_full;

    assign en        = !vld_reg[FRONT_STAGES-1] || job_ready;
    assign in_ready  = en;
    assign job_valid = vld_reg[FRONT_STAGES-1];
    assign job       = job_reg;

    always_comb
    begin
        diff_next = $signed({1'b0, adc_t_s0_reg[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
        d_next    = $signed({2'b0, adc_t_s0_reg[19:4]}) - $signed({2'b0, cal.t1});
        dsq       = 36'(d_next) * 36'(d_next);
        t5        = 30'(fine_s3_reg) * 30'sd5 + 30'sd128;
        xsq       = 54'(x_s4_reg) * 54'(x_s4_reg);
        y6_full   = 71'($signed({1'b0, xx_s5_reg})) * 71'($signed(cal.p6));
        x3_full   = 71'($signed({1'b0, xx_s5_reg})) * 71'($signed(cal.p3));
        xp5_ext   = 64'(xp5_s6_reg);
        xp2_ext   = 64'(xp2_s6_reg);
        p4_ext    = 64'($signed(cal.p4));
        xs_u      = xs_s7_reg + PRESS_BIAS;
        xm_full   = 80'(xs_u) * 80'(cal.p1);
        n_full    = 76'(n0_s8_reg) * 76'(DIV_SCALE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            adc_t_s0_reg <= raw_temperature;
            adc_p_s0_reg <= raw_pressure;

            ta_s1_reg <= 35'(diff_next) * 35'($signed(cal.t2));
            dd_s1_reg <= dsq[32:0];
            pb_s1_reg <= PRESS_BASE - {1'b0, adc_p_s0_reg};

            a_s2_reg  <= ta_s1_reg[34:11];
            b1_s2_reg <= 38'($signed({1'b0, dd_s1_reg[32:12]})) * 38'($signed(cal.t3));
            pb_s2_reg <= pb_s1_reg;

            fine_s3_reg <= 26'(a_s2_reg) + 26'($signed(b1_s2_reg[37:14]));
            pb_s3_reg   <= pb_s2_reg;

            x_s4_reg    <= 27'(fine_s3_reg) - 27'sd128000;
            temp_s4_reg <= 32'($signed(t5[29:8]));
            pb_s4_reg   <= pb_s3_reg;

            xx_s5_reg   <= xsq;
            xp5_s5_reg  <= 43'(x_s4_reg) * 43'($signed(cal.p5));
            xp2_s5_reg  <= 43'(x_s4_reg) * 43'($signed(cal.p2));
            temp_s5_reg <= temp_s4_reg;
            pb_s5_reg   <= pb_s4_reg;

            y6_s6_reg   <= y6_full[63:0];
            x3_s6_reg   <= x3_full[63:0];
            xp5_s6_reg  <= xp5_s5_reg;
            xp2_s6_reg  <= xp2_s5_reg;
            temp_s6_reg <= temp_s5_reg;
            pb_s6_reg   <= pb_s5_reg;

            y_s7_reg    <= y6_s6_reg + {xp5_ext[46:0], 17'b0} + {p4_ext[28:0], 35'b0};
            xs_s7_reg   <= 64'($signed(x3_s6_reg[63:8])) + {xp2_ext[51:0], 12'b0};
            temp_s7_reg <= temp_s6_reg;
            pb_s7_reg   <= pb_s6_reg;

            xm_s8_reg   <= xm_full[63:0];
            n0_s8_reg   <= {12'b0, pb_s7_reg, 31'b0} - y_s7_reg;
            temp_s8_reg <= temp_s7_reg;

            job_reg.temp    <= temp_s8_reg;
            job_reg.numer   <= n_full[63:0];
            job_reg.divisor <= xm_s8_reg[63:33];
            job_reg.invalid <= (xm_s8_reg[63:33] == '0);
        end
    end

endmodule

/* design/ptc_fifo.sv */
`include "assert_macros.svh"

module ptc_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  ptc_pkg::job_t push_word,
    output logic          pop_valid,
    input  logic          pop_ready,
    output ptc_pkg::job_t pop_word
);
    import ptc_pkg::*;

    job_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               push, pop;

    assign push_ready = (count_reg != FIFO_CW'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_ready && pop_valid;
    assign pop_word   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    `ASSERT_ALWAYS(a_fifo_count_max, clk, count_reg <= FIFO_CW'(FIFO_DEPTH), "fifo count overrun")
    `ASSERT_AT(a_fifo_empty_ptrs, clk, rst_n, (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg), "fifo pointers disagree when empty")
    `ASSERT_AT(a_fifo_push_count, clk, rst_n, (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1), "fifo count missed a push")

endmodule

/* design/ptc_back.sv */
`include "assert_macros.svh"

module ptc_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ptc_pkg::cal_t             cal,
    input  logic                      job_valid,
    output logic                      job_ready,
    input  ptc_pkg::job_t             job,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ptc_pkg::OUT_W-1:0] temp_centidegrees,
    output logic [ptc_pkg::OUT_W-1:0] pressure_q24_8,
    output logic                      pressure_invalid
);
    import ptc_pkg::*;

    logic en;

    // divider pipe: entry 0 holds magnitudes, entries 1..DIV_STAGES one quotient bit each
    logic              dv_reg   [DIV_STAGES+1];
    logic [DIVR_W-1:0] rem_reg  [DIV_STAGES+1];
    logic [63:0]       qn_reg   [DIV_STAGES+1];
    logic [DIVR_W-1:0] ub_reg   [DIV_STAGES+1];
    logic              neg_reg  [DIV_STAGES+1];
    logic              inv_reg  [DIV_STAGES+1];
    logic [OUT_W-1:0]  temp_reg [DIV_STAGES+1];

    logic [TAIL_STAGES-1:0] tv_reg;
    logic [63:0]       p_b1_reg, p_b2_reg, p_b3_reg, p_b4_reg;
    logic [63:0]       pp0_b2_reg, c8_b2_reg, c8_b3_reg, c8_b4_reg;
    logic [31:0]       pp1_b2_reg;
    logic [63:0]       pss_b3_reg, c9_b4_reg, s_b5_reg, r_b6_reg;
    logic              inv_b1_reg, inv_b2_reg, inv_b3_reg, inv_b4_reg, inv_b5_reg, inv_b6_reg;
    logic [OUT_W-1:0]  t_b1_reg, t_b2_reg, t_b3_reg, t_b4_reg, t_b5_reg, t_b6_reg;
    logic [OUT_W-1:0]  temp_out_reg, press_out_reg;
    logic              inv_out_reg;

    logic [63:0]       ps, p7_ext, sat_val;
    logic [79:0]       c8_full, c9_full;
    logic [63:0]       q_last;

    assign en        = !tv_reg[TAIL_STAGES-1] || out_ready;
    assign job_ready = en;

    assign out_valid         = tv_reg[TAIL_STAGES-1];
    assign temp_centidegrees = temp_out_reg;
    assign pressure_q24_8    = press_out_reg;
    assign pressure_invalid  = inv_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_reg[0] <= job_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            qn_reg[0]   <= job.numer[63] ? (64'd0 - job.numer) : job.numer;
            ub_reg[0]   <= job.divisor[DIVR_W-1] ? (DIVR_W'(0) - job.divisor) : job.divisor;
            neg_reg[0]  <= job.numer[63] ^ job.divisor[DIVR_W-1];
            inv_reg[0]  <= job.invalid;
            temp_reg[0] <= job.temp;
        end
    end

    for (genvar k = 1; k <= DIV_STAGES; k++)
    begin : g_div
        logic [DIVR_W:0] r2, diff;
        logic            ge;

        assign r2   = {rem_reg[k-1], qn_reg[k-1][63]};
        assign diff = r2 - {1'b0, ub_reg[k-1]};
        assign ge   = (r2 >= {1'b0, ub_reg[k-1]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[k] <= dv_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? diff[DIVR_W-1:0] : r2[DIVR_W-1:0];
                qn_reg[k]   <= {qn_reg[k-1][62:0], ge};
                ub_reg[k]   <= ub_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                inv_reg[k]  <= inv_reg[k-1];
                temp_reg[k] <= temp_reg[k-1];
            end
        end
    end

    always_comb
    begin
        q_last  = qn_reg[DIV_STAGES];
        ps      = 64'($signed(p_b1_reg[63:13]));
        c8_full = 80'($signed(p_b1_reg)) * 80'($signed(cal.p8));
        c9_full = 80'($signed(pss_b3_reg)) * 80'($signed(cal.p9));
        p7_ext  = 64'($signed(cal.p7));
        if (inv_b6_reg || r_b6_reg[63])
        begin
            sat_val = '0;
        end
        else if (r_b6_reg[62:32] != '0)
        begin
            sat_val = 64'h0000_0000_FFFF_FFFF;
        end
        else
        begin
            sat_val = r_b6_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg <= '0;
        end
        else if (en)
        begin
            tv_reg <= {tv_reg[TAIL_STAGES-2:0], dv_reg[DIV_STAGES]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_b1_reg   <= neg_reg[DIV_STAGES] ? (64'd0 - q_last) : q_last;
            inv_b1_reg <= inv_reg[DIV_STAGES];
            t_b1_reg   <= temp_reg[DIV_STAGES];

            pp0_b2_reg <= 64'(ps[31:0]) * 64'(ps[31:0]);
            pp1_b2_reg <= ps[63:32] * ps[31:0];
            c8_b2_reg  <= c8_full[63:0];
            p_b2_reg   <= p_b1_reg;
            inv_b2_reg <= inv_b1_reg;
            t_b2_reg   <= t_b1_reg;

            pss_b3_reg <= pp0_b2_reg + {pp1_b2_reg[30:0], 33'b0};
            c8_b3_reg  <= c8_b2_reg;
            p_b3_reg   <= p_b2_reg;
            inv_b3_reg <= inv_b2_reg;
            t_b3_reg   <= t_b2_reg;

            c9_b4_reg  <= c9_full[63:0];
            c8_b4_reg  <= c8_b3_reg;
            p_b4_reg   <= p_b3_reg;
            inv_b4_reg <= inv_b3_reg;
            t_b4_reg   <= t_b3_reg;

            s_b5_reg   <= p_b4_reg + 64'($signed(c9_b4_reg[63:25]))
                                   + 64'($signed(c8_b4_reg[63:19]));
            inv_b5_reg <= inv_b4_reg;
            t_b5_reg   <= t_b4_reg;

            r_b6_reg   <= 64'($signed(s_b5_reg[63:8])) + {p7_ext[59:0], 4'b0};
            inv_b6_reg <= inv_b5_reg;
            t_b6_reg   <= t_b5_reg;

            temp_out_reg  <= t_b6_reg;
            press_out_reg <= sat_val[31:0];
            inv_out_reg   <= inv_b6_reg;
        end
    end

    `ASSERT_AT(a_back_invalid_zero, clk, rst_n, (out_valid && pressure_invalid) |-> (pressure_q24_8 == '0), "invalid pressure word not zero")

endmodule

/* design/pressure_temperature_compensation.sv */
// Barometric temperature and pressure compensation.
// Input channel (in_valid/in_ready): one word is a raw temperature and raw
// pressure reading pair. Output channel (out_valid/out_ready): one word per
// input, temperature in 0.01 C, pressure in Pa as Q24.8 saturated to 32 bits,
// and an invalid flag when the pressure divisor is zero (pressure then 0).
// Calibration: four 48-bit registers written with cfg_we/cfg_index/cfg_data;
// the user must write them only while no word is in flight (not enforced here).
// Throughput: one word per cycle when the output is not stalled. Path from
// input accept to output valid: a 10-stage front (temperature and polynomial),
// a registered pass through the 4-word queue, and a 72-stage back end dominated
// by the 64-stage radix-2 divider, one quotient bit per stage.
// Reset clears all valid state and the calibration registers to zero.
// When the receiver stalls, the back end holds and the queue fills; the front
// keeps accepting until the queue is full, then in_ready drops.
module pressure_temperature_compensation (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [ptc_pkg::CAL_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ptc_pkg::RAW_W-1:0] raw_temperature,
    input  logic [ptc_pkg::RAW_W-1:0] raw_pressure,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ptc_pkg::OUT_W-1:0] temp_centidegrees,
    output logic [ptc_pkg::OUT_W-1:0] pressure_q24_8,
    output logic                      pressure_invalid
);
    import ptc_pkg::*;

    logic [CAL_W-1:0] temp_calib_reg, press_low_reg, press_mid_reg, press_high_reg;
    cal_t             cal;
    logic             fq_valid, fq_ready, qb_valid, qb_ready;
    job_t             fq_word, qb_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_calib_reg <= '0;
            press_low_reg  <= '0;
            press_mid_reg  <= '0;
            press_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_TEMP_CALIB: temp_calib_reg <= cfg_data;
                REG_PRESS_LOW:  press_low_reg  <= cfg_data;
                REG_PRESS_MID:  press_mid_reg  <= cfg_data;
                REG_PRESS_HIGH: press_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cal.t1 = temp_calib_reg[15:0];
        cal.t2 = temp_calib_reg[31:16];
        cal.t3 = temp_calib_reg[47:32];
        cal.p1 = press_low_reg[15:0];
        cal.p2 = press_low_reg[31:16];
        cal.p3 = press_low_reg[47:32];
        cal.p4 = press_mid_reg[15:0];
        cal.p5 = press_mid_reg[31:16];
        cal.p6 = press_mid_reg[47:32];
        cal.p7 = press_high_reg[15:0];
        cal.p8 = press_high_reg[31:16];
        cal.p9 = press_high_reg[47:32];
    end

    ptc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cal             (cal),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .raw_temperature (raw_temperature),
        .raw_pressure    (raw_pressure),
        .job_valid       (fq_valid),
        .job_ready       (fq_ready),
        .job             (fq_word)
    );

    ptc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_word  (fq_word),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_word   (qb_word)
    );

    ptc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cal               (cal),
        .job_valid         (qb_valid),
        .job_ready         (qb_ready),
        .job               (qb_word),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .temp_centidegrees (temp_centidegrees),
        .pressure_q24_8    (pressure_q24_8),
        .pressure_invalid  (pressure_invalid)
    );

endmodule

/* verif/tb_pressure_temperature_compensation.sv */
module tb_pressure_temperature_compensation;
    import ptc_pkg::*;

    localparam int LATENCY   = 83;
    localparam int IDLE_WAIT = LATENCY + 16;
    localparam int MAX_CYCLES = 400000;

    typedef struct {
        logic [31:0] temp;
        logic [31:0] press;
        logic        invalid;
    } reading_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    reg_idx_t            cfg_index;
    logic [CAL_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic [RAW_W-1:0]    raw_temperature;
    logic [RAW_W-1:0]    raw_pressure;
    logic                out_valid;
    logic                out_ready;
    logic [OUT_W-1:0]    temp_centidegrees;
    logic [OUT_W-1:0]    pressure_q24_8;
    logic                pressure_invalid;

    logic [CAL_W-1:0] cal_regs [4];
    reading_t         pending_readings [$];
    int               err_cnt;
    int               cycle_cnt;
    logic             in_taken;
    int               burst_left;

    pressure_temperature_compensation dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .raw_temperature   (raw_temperature),
        .raw_pressure      (raw_pressure),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .temp_centidegrees (temp_centidegrees),
        .pressure_q24_8    (pressure_q24_8),
        .pressure_invalid  (pressure_invalid)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic signed [63:0] cal_s(input logic [CAL_W-1:0] r, input int k);
        logic [15:0] w;
        begin
            w = r[16*k +: 16];
            return {{48{w[15]}}, w};
        end
    endfunction

    function automatic logic signed [63:0] cal_u(input logic [CAL_W-1:0] r, input int k);
        return {48'b0, r[16*k +: 16]};
    endfunction

    // 64-bit signed divide, truncating, built on unsigned magnitudes
    function automatic logic signed [63:0] div_trunc(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] q;
        begin
            ua = a[63] ? (64'd0 - a) : a;
            ub = b[63] ? (64'd0 - b) : b;
            q  = ua / ub;
            return (a[63] != b[63]) ? (64'd0 - q) : q;
        end
    endfunction

    function automatic reading_t compensate(input logic [19:0] rt, input logic [19:0] rp);
        logic signed [63:0] adc_t, adc_p;
        logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] a, d, b, fine, temp, x, y, p, ps, c9, c8;
        reading_t r;
        begin
            adc_t = {44'b0, rt};
            adc_p = {44'b0, rp};
            t1 = cal_u(cal_regs[REG_TEMP_CALIB], 0);
            t2 = cal_s(cal_regs[REG_TEMP_CALIB], 1);
            t3 = cal_s(cal_regs[REG_TEMP_CALIB], 2);
            p1 = cal_u(cal_regs[REG_PRESS_LOW], 0);
            p2 = cal_s(cal_regs[REG_PRESS_LOW], 1);
            p3 = cal_s(cal_regs[REG_PRESS_LOW], 2);
            p4 = cal_s(cal_regs[REG_PRESS_MID], 0);
            p5 = cal_s(cal_regs[REG_PRESS_MID], 1);
            p6 = cal_s(cal_regs[REG_PRESS_MID], 2);
            p7 = cal_s(cal_regs[REG_PRESS_HIGH], 0);
            p8 = cal_s(cal_regs[REG_PRESS_HIGH], 1);
            p9 = cal_s(cal_regs[REG_PRESS_HIGH], 2);

            a    = (((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
            d    = (adc_t >>> 4) - t1;
            b    = (((d * d) >>> 12) * t3) >>> 14;
            fine = a + b;
            temp = (fine * 64'sd5 + 64'sd128) >>> 8;

            x = fine - 64'sd128000;
            y = x * x * p6;
            y = y + ((x * p5) <<< 17);
            y = y + (p4 <<< 35);
            x = ((x * x * p3) >>> 8) + ((x * p2) <<< 12);
            x = (((64'sd1 <<< 47) + x) * p1) >>> 33;

            r.temp = temp[31:0];
            if (x == 64'sd0)
            begin
                r.press   = 32'd0;
                r.invalid = 1'b1;
            end
            else
            begin
                p  = 64'sd1048576 - adc_p;
                p  = div_trunc(((p <<< 31) - y) * 64'sd3125, x);
                ps = p >>> 13;
                c9 = (p9 * ps * ps) >>> 25;
                c8 = (p8 * p) >>> 19;
                p  = ((p + c9 + c8) >>> 8) + (p7 <<< 4);
                if (p[63])
                    r.press = 32'd0;
                else if ($unsigned(p) > 64'hFFFF_FFFF)
                    r.press = 32'hFFFF_FFFF;
                else
                    r.press = p[31:0];
                r.invalid = 1'b0;
            end
            return r;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        begin
            $display("MISMATCH %s: got %0h, expected %0h at cycle %0d", what, got, want,
                     cycle_cnt);
            err_cnt++;
        end
    endtask

    // input monitor: predict on acceptance
    always @(posedge clk)
    begin
        in_taken = in_valid && in_ready && rst_n;
        if (in_taken)
            pending_readings.push_back(compensate(raw_temperature, raw_pressure));
    end

    // output checker
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_readings.size() == 0)
                report_mismatch("unexpected word", {32'b0, pressure_q24_8}, 64'd0);
            else
            begin
                want = pending_readings.pop_front();
                if (temp_centidegrees !== want.temp)
                    report_mismatch("temp_centidegrees", 64'(temp_centidegrees),
                                    64'(want.temp));
                if (pressure_q24_8 !== want.press)
                    report_mismatch("pressure_q24_8", 64'(pressure_q24_8), 64'(want.press));
                if (pressure_invalid !== want.invalid)
                    report_mismatch("pressure_invalid", 64'(pressure_invalid),
                                    64'(want.invalid));
            end
        end
    end

    // receiver stall pattern, cycling through four modes
    always @(negedge clk)
    begin
        case ((cycle_cnt / 64) % 4)
            0: out_ready = 1'b1;
            1: out_ready = ($urandom_range(1, 0) == 1);
            2: out_ready = ((cycle_cnt % 5) == 0);
            default: out_ready = ($urandom_range(7, 0) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > MAX_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_word(input logic [19:0] rt, input logic [19:0] rp);
        begin
            if (burst_left == 0)
            begin
                in_valid = 1'b0;
                repeat ($urandom_range(6, 1)) @(negedge clk);
                burst_left = $urandom_range(40, 1);
            end
            burst_left--;
            in_valid        = 1'b1;
            raw_temperature = rt;
            raw_pressure    = rp;
            do
                @(negedge clk);
            while (!in_taken);
        end
    endtask

    task automatic wait_idle();
        begin
            in_valid = 1'b0;
            while (pending_readings.size() != 0)
                @(negedge clk);
            repeat (IDLE_WAIT) @(negedge clk);
        end
    endtask

    task automatic write_cal(input reg_idx_t idx, input logic [CAL_W-1:0] v);
        begin
            cfg_we    = 1'b1;
            cfg_index = idx;
            cfg_data  = v;
            cal_regs[idx] = v;
            @(negedge clk);
            cfg_we = 1'b0;
        end
    endtask

    task automatic load_cal(input logic [CAL_W-1:0] tc, input logic [CAL_W-1:0] pl,
                            input logic [CAL_W-1:0] pm, input logic [CAL_W-1:0] ph);
        begin
            wait_idle();
            write_cal(REG_TEMP_CALIB, tc);
            write_cal(REG_PRESS_LOW, pl);
            write_cal(REG_PRESS_MID, pm);
            write_cal(REG_PRESS_HIGH, ph);
        end
    endtask

    function automatic logic [15:0] near(input int base, input int span);
        return 16'(base + $signed($urandom_range(2 * span, 0)) - span);
    endfunction

    // typical factory words with some spread
    task automatic load_typical(input int span);
        begin
            load_cal({near(-1000, span), near(26435, span), near(27504, span)},
                     {near(3024, span), near(-10685, span), near(36477, span)},
                     {near(-7, span), near(140, span), near(2855, span)},
                     {near(6000, span), near(-14600, span), near(15500, span)});
        end
    endtask

    function automatic logic [CAL_W-1:0] rand_cal();
        return CAL_W'({$urandom, $urandom});
    endfunction

    task automatic send_random_raw();
        begin
            if ($urandom_range(1, 0) == 1)
                send_word(20'(519888 + $signed($urandom_range(200000, 0)) - 100000),
                          20'(415148 + $signed($urandom_range(400000, 0)) - 200000));
            else
                send_word(20'($urandom), 20'($urandom));
        end
    endtask

    task automatic test_reset_calibration();
        begin
            send_word(20'd519888, 20'd415148);
            send_word(20'hFFFFF, 20'h00000);
        end
    endtask

    task automatic test_typical_extremes();
        begin
            load_typical(0);
            send_word(20'd519888, 20'd415148);
            send_word(20'h00000, 20'h00000);
            send_word(20'hFFFFF, 20'hFFFFF);
            send_word(20'h00000, 20'hFFFFF);
            send_word(20'hFFFFF, 20'h00000);
            send_word(20'h55555, 20'hAAAAA);
        end
    endtask

    task automatic test_zero_divisor();
        begin
            load_cal({16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd0},
                     cal_regs[REG_PRESS_MID], cal_regs[REG_PRESS_HIGH]);
            send_word(20'd519888, 20'd415148);
            send_word(20'hFFFFF, 20'hFFFFF);
            send_word(20'h00000, 20'h00000);
        end
    endtask

    task automatic test_calibration_extremes();
        begin
            load_cal({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}});
            send_word(20'h00000, 20'h00000);
            send_word(20'hFFFFF, 20'hFFFFF);
            send_word(20'd519888, 20'd415148);
            send_word(20'hAAAAA, 20'h55555);
            load_cal({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
            send_word(20'h00000, 20'hFFFFF);
            send_word(20'hFFFFF, 20'h00000);
            send_word(20'd519888, 20'd415148);
            send_word(20'h12345, 20'h6789A);
            load_cal({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
            send_word(20'h00000, 20'h00000);
            send_word(20'hFFFFF, 20'hFFFFF);
            send_word(20'd519888, 20'd415148);
            send_word(20'h80000, 20'h7FFFF);
        end
    endtask

    task automatic test_random_typical();
        begin
            for (int ph = 0; ph < 3; ph++)
            begin
                load_typical(ph * 3000);
                for (int i = 0; i < 150; i++)
                    send_random_raw();
            end
        end
    endtask

    task automatic test_random_calibration();
        begin
            for (int ph = 0; ph < 4; ph++)
            begin
                load_cal(rand_cal(), rand_cal(), rand_cal(), rand_cal());
                for (int i = 0; i < 65; i++)
                    send_random_raw();
            end
        end
    endtask

    initial
    begin
        burst_left      = 0;
        cfg_we          = 1'b0;
        cfg_index       = REG_TEMP_CALIB;
        cfg_data        = '0;
        in_valid        = 1'b0;
        raw_temperature = '0;
        raw_pressure    = '0;
        for (int i = 0; i < 4; i++)
            cal_regs[i] = '0;
        rst_n = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_calibration();
        test_typical_extremes();
        test_zero_divisor();
        test_calibration_extremes();
        test_random_typical();
        test_random_calibration();

        wait_idle();
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/ptc_pkg.sv
design/ptc_front.sv
design/ptc_fifo.sv
design/ptc_back.sv
design/pressure_temperature_compensation.sv
verif/tb_pressure_temperature_compensation.sv
